>>> sv/spq_pkg.sv
// Package for the sorted priority queue core.
// Holds the request and status codes and the fixed field widths.
// No dependencies.
`default_nettype none

package spq_pkg;

	localparam int VALUE_IN_W  = 32;
	localparam int VALUE_OUT_W = 32;
	localparam int STATUS_W    = 2;
	localparam int OCC_W       = 5;

	typedef logic [STATUS_W-1:0] status_t;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_FULL  = 2'd1;
	localparam status_t STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

>>> sv/spq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the value store of the sorted priority queue. No dependencies.
`default_nettype none

module spq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a descending, circular value store
// with an insertion sequencer. Depends on spq_pkg and spq_ram.
//
// Channel   Direction  Handshake               Payload
// request   in         start high, busy low    req_type, value_in
// result    out        done, one-cycle strobe  value_out, status, occupancy,
//                                              is_empty, is_full
//
// A refused request or an enqueue into an empty queue answers in the cycle after
// acceptance; a dequeue answers after passing through S_DEQ_RD and S_DEQ_DATA.
// An enqueue into a queue holding N values walks from the tail through one
// RAM read port and one write port: S_ENQ_RD, S_ENQ_CMP per value, S_ENQ_PUT at the head.
// Reset clears the count and head; the store itself is never cleared.
// The result is shown for one cycle only; a new request may start in that cycle.
`default_nettype none

module sorted_priority_queue_core
	import spq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   req_type,
	input  wire logic [VALUE_IN_W-1:0]  value_in,
	output logic                        done,
	output logic      [VALUE_OUT_W-1:0] value_out,
	output logic      [STATUS_W-1:0]    status,
	output logic      [OCC_W-1:0]       occupancy,
	output logic                        is_empty,
	output logic                        is_full
);

	localparam int IdxW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);
	localparam int SumW = CntW + 1;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_ENQ_RD   = 3'd1;
	localparam logic [2:0] S_ENQ_CMP  = 3'd2;
	localparam logic [2:0] S_ENQ_PUT  = 3'd3;
	localparam logic [2:0] S_DEQ_RD   = 3'd4;
	localparam logic [2:0] S_DEQ_DATA = 3'd5;

	logic [2:0]             state_q;
	logic [IdxW-1:0]        head_q;
	logic [CntW-1:0]        count_q;
	logic [CntW-1:0]        pos_q;
	logic [VALUE_BITS-1:0]  val_q;
	logic                   done_q;
	logic [VALUE_OUT_W-1:0] value_out_q;
	status_t                status_q;

	logic                        accept;
	logic                        full;
	logic                        empty;
	logic [VALUE_BITS+VALUE_IN_W-1:0]  in_ext;
	logic [VALUE_BITS-1:0]             v_in;
	logic [VALUE_BITS+VALUE_OUT_W-1:0] out_ext;
	logic [CntW+OCC_W-1:0]             occ_ext;
	logic [CntW-1:0]        pos_sel;
	logic [SumW-1:0]        slot_sum;
	logic [IdxW-1:0]        slot;
	logic                   ram_we;
	logic [VALUE_BITS-1:0]  ram_wdata;
	logic [VALUE_BITS-1:0]  ram_rdata;
	logic                   entry_less;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CntW'(DEPTH));
	assign empty  = (count_q == '0);

	// The value is kept at VALUE_BITS; the result field is zero-extended or cut.
	assign in_ext  = {{VALUE_BITS{1'b0}}, value_in};
	assign v_in    = in_ext[VALUE_BITS-1:0];
	assign out_ext = {{VALUE_OUT_W{1'b0}}, ram_rdata};

	// Shared slot unit: position relative to the head, wrapped into the store.
	always_comb begin
		case (state_q)
			S_ENQ_RD:  pos_sel = pos_q - CntW'(1);
			S_ENQ_CMP: pos_sel = pos_q;
			S_ENQ_PUT: pos_sel = pos_q;
			default:   pos_sel = '0;
		endcase
		slot_sum = SumW'(head_q) + SumW'(pos_sel);
		if (slot_sum >= SumW'(DEPTH)) begin
			slot_sum = slot_sum - SumW'(DEPTH);
		end
		slot = slot_sum[IdxW-1:0];
	end

	// Shared compare unit: a stored value strictly below the new one moves back.
	assign entry_less = ($signed(ram_rdata) < $signed(val_q));

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = val_q;
		case (state_q)
			S_IDLE: begin
				ram_we    = accept && (req_type == REQ_ENQ) && empty;
				ram_wdata = v_in;
			end
			S_ENQ_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = entry_less ? ram_rdata : val_q;
			end
			S_ENQ_PUT: begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
			end
			default: begin
				ram_we    = 1'b0;
				ram_wdata = val_q;
			end
		endcase
	end

	spq_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot),
		.wdata(ram_wdata),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == REQ_ENQ) begin
							if (full) begin
								done_q <= 1'b1;
							end else if (empty) begin
								count_q <= CntW'(1);
								done_q  <= 1'b1;
							end else begin
								state_q <= S_ENQ_RD;
							end
						end else begin
							if (empty) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_DEQ_RD;
							end
						end
					end
				end
				S_ENQ_RD: begin
					state_q <= S_ENQ_CMP;
				end
				S_ENQ_CMP: begin
					if (!entry_less) begin
						count_q <= count_q + CntW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (pos_q == CntW'(1)) begin
						state_q <= S_ENQ_PUT;
					end else begin
						state_q <= S_ENQ_RD;
					end
				end
				S_ENQ_PUT: begin
					count_q <= count_q + CntW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DEQ_RD: begin
					state_q <= S_DEQ_DATA;
				end
				S_DEQ_DATA: begin
					count_q <= count_q - CntW'(1);
					if (count_q == CntW'(1)) begin
						head_q <= '0;
					end else if (head_q == IdxW'(DEPTH - 1)) begin
						head_q <= '0;
					end else begin
						head_q <= head_q + IdxW'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working value, tail position and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q       <= v_in;
					pos_q       <= count_q;
					value_out_q <= '0;
					if (req_type == REQ_ENQ) begin
						status_q <= full ? STATUS_FULL : STATUS_OK;
					end else begin
						status_q <= empty ? STATUS_EMPTY : STATUS_OK;
					end
				end
			end
			S_ENQ_CMP: begin
				if (entry_less) begin
					pos_q <= pos_q - CntW'(1);
				end
			end
			S_DEQ_DATA: begin
				value_out_q <= out_ext[VALUE_OUT_W-1:0];
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign occ_ext   = {{OCC_W{1'b0}}, count_q};
	assign done      = done_q;
	assign value_out = value_out_q;
	assign status    = status_q;
	assign occupancy = occ_ext[OCC_W-1:0];
	assign is_empty  = empty;
	assign is_full   = full;

endmodule

`default_nettype wire

>>> tb/sv/sorted_priority_queue_core_tb.sv
// Self-checking testbench for sorted_priority_queue_core: drives enqueue and dequeue
// requests, predicts each response from a sorted model of the queue, and checks every field.
// Depends on spq_pkg and the sorted_priority_queue_core RTL.
`timescale 1ns / 100ps

module sorted_priority_queue_core_tb;
	import spq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 32;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

	typedef struct packed {
		logic [VALUE_OUT_W-1:0] value;
		status_t                stat;
		logic [OCC_W-1:0]       occ;
		logic                   empty;
		logic                   full;
	} queue_response_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   req_type = REQ_ENQ;
	logic [VALUE_IN_W-1:0]  value_in = '0;
	wire                    busy;
	wire                    done;
	wire [VALUE_OUT_W-1:0]  value_out;
	wire [STATUS_W-1:0]     status;
	wire [OCC_W-1:0]        occupancy;
	wire                    is_empty;
	wire                    is_full;

	// Values currently held, largest first; equal values in arrival order.
	logic signed [VALUE_BITS-1:0] held_values[$];
	queue_response_t pending_responses[$];

	int error_count = 0;
	int sender_gap_pct = 0;
	int enq_ok_count = 0;
	int deq_ok_count = 0;
	int full_refused_count = 0;
	int empty_refused_count = 0;
	int checked_count = 0;

	sorted_priority_queue_core #(
		.DEPTH(DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value_in(value_in),
		.done(done),
		.value_out(value_out),
		.status(status),
		.occupancy(occupancy),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	always #6 clk = ~clk;

	initial begin
		#6ms;
		$display("simulation failed");
		$finish;
	end

	// Applies one request to the held values and returns the response it must produce.
	function automatic queue_response_t compute_queue_response(logic req,
			logic [VALUE_IN_W-1:0] val);
		queue_response_t rsp;
		logic signed [VALUE_BITS-1:0] v;
		int pos;
		rsp = '0;
		rsp.stat = STATUS_OK;
		v = val;
		if (req == REQ_ENQ) begin
			if (held_values.size() >= DEPTH) begin
				rsp.stat = STATUS_FULL;
				full_refused_count++;
			end else begin
				pos = 0;
				while (pos < held_values.size() && held_values[pos] >= v)
					pos++;
				held_values.insert(pos, v);
				enq_ok_count++;
			end
		end else begin
			if (held_values.size() == 0) begin
				rsp.stat = STATUS_EMPTY;
				empty_refused_count++;
			end else begin
				rsp.value = held_values.pop_front();
				deq_ok_count++;
			end
		end
		rsp.occ   = OCC_W'(held_values.size());
		rsp.empty = (held_values.size() == 0);
		rsp.full  = (held_values.size() >= DEPTH);
		return rsp;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: mismatch on %s: got 0x%08h, wanted 0x%08h", $time, what, got, want);
		error_count++;
	endtask

	// Every response is compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		queue_response_t want;
		if (arst_n && done) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("result with no outstanding transaction", value_out, '0);
			end else begin
				want = pending_responses.pop_front();
				checked_count++;
				if (value_out !== want.value)
					report_mismatch("value_out", value_out, want.value);
				if (status !== want.stat)
					report_mismatch("status", 32'(status), 32'(want.stat));
				if (occupancy !== want.occ)
					report_mismatch("occupancy", 32'(occupancy), 32'(want.occ));
				if (is_empty !== want.empty)
					report_mismatch("is_empty", 32'(is_empty), 32'(want.empty));
				if (is_full !== want.full)
					report_mismatch("is_full", 32'(is_full), 32'(want.full));
			end
		end
	end

	// Holds one request until the block takes it, then idles at random.
	task automatic send_request(logic req, logic [VALUE_IN_W-1:0] val);
		start    <= 1'b1;
		req_type <= req;
		value_in <= val;
		do
			@(posedge clk);
		while (busy);
		pending_responses.push_back(compute_queue_response(req, val));
		if ($urandom_range(1, 100) <= sender_gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic [VALUE_IN_W-1:0] random_value();
		logic [VALUE_IN_W-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 6) - 3;
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7fff_ffff;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					default: v = 32'hffff_ffff;
				endcase
			end
			4: v = $urandom_range(0, 255);
			default: v = -$urandom_range(1, 255);
		endcase
		return v;
	endfunction

	task automatic test_dequeue_when_empty();
		send_request(REQ_DEQ, 32'h1234_5678);
	endtask

	// Fills the queue with extremes and repeated values, then overruns it once.
	task automatic test_fill_to_full();
		logic [VALUE_IN_W-1:0] fill_values[DEPTH];
		fill_values = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
			32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'hffff_fffb,
			32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h5555_5555,
			32'haaaa_aaaa, 32'h0000_0005, 32'h7fff_fffe, 32'h8000_0001};
		foreach (fill_values[i])
			send_request(REQ_ENQ, fill_values[i]);
		send_request(REQ_ENQ, 32'h0000_0042);
	endtask

	task automatic test_partial_drain();
		repeat (6) send_request(REQ_DEQ, $urandom);
	endtask

	// The enqueue share swings over time so the queue keeps reaching full and empty.
	task automatic test_random_traffic(int items, int gap_pct);
		int enq_pct;
		sender_gap_pct = gap_pct;
		enq_pct = 50;
		for (int n = 0; n < items; n++) begin
			if (n % 48 == 0) begin
				case ($urandom_range(0, 3))
					0: enq_pct = 85;
					1: enq_pct = 15;
					2: enq_pct = 50;
					default: enq_pct = 60;
				endcase
			end
			if ($urandom_range(1, 100) <= enq_pct)
				send_request(REQ_ENQ, random_value());
			else
				send_request(REQ_DEQ, $urandom);
		end
	endtask

	initial begin
		int wait_cycles;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_gap_pct = 28;
		test_dequeue_when_empty();
		test_fill_to_full();
		test_partial_drain();

		test_random_traffic(700, 28);
		test_random_traffic(700, 66);
		test_random_traffic(600, 0);
		start <= 1'b0;

		wait_cycles = 0;
		while (pending_responses.size() != 0 && wait_cycles < 4 * DRAIN_CYCLES) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_responses.size() != 0)
			report_mismatch("responses still outstanding", 32'(pending_responses.size()), '0);

		$display("Checked %0d responses: %0d enqueues stored, %0d values removed,",
			checked_count, enq_ok_count, deq_ok_count);
		$display("%0d enqueues refused as full, %0d dequeues refused as empty, %0d errors.",
			full_refused_count, empty_refused_count, error_count);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
